/* hdl/fixed_width_decimal_formatter_macros.svh */
// Assertion macros shared by the decimal formatter RTL.
`ifndef FIXED_WIDTH_DECIMAL_FORMATTER_MACROS_SVH
`define FIXED_WIDTH_DECIMAL_FORMATTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// ante true implies cons true in the same cycle
`define FWDF_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fwdf assertion failed");
// cond never true
`define FWDF_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("fwdf assertion failed");
`else
`define FWDF_ASSERT_HOLDS(label, clk, rst, ante, cons)
`define FWDF_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* hdl/fwdf_pkg.sv */
// Shared types and constants of the decimal formatter.
package fwdf_pkg;

   localparam int VALUE_W   = 64;
   localparam int MAX_WIDTH = 20;
   localparam int DIGITS    = 20;
   localparam int BCD_W     = DIGITS * 4;
   localparam int SIG_W     = $clog2(DIGITS + 1);
   localparam int DIG_IDX_W = $clog2(DIGITS);
   localparam int POS_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = 5;
   localparam int STEP_BITS = 4;
   localparam int STEPS     = VALUE_W / STEP_BITS;
   localparam int CNT_W     = $clog2(STEPS);
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAC_DIGITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_PAD    = 2'd2;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_POINT = 8'h2e;

   typedef logic [DIGITS-1:0][3:0] bcd_type;

   typedef struct packed {
      logic             neg;
      bcd_type          bcd;
      logic [SIG_W-1:0] sig;
   } digit_entry_type;

   typedef struct packed {
      logic [FW_W-1:0] width;
      logic [FW_W-1:0] frac;
      logic            zero_pad;
   } fmt_cfg_type;

endpackage

/* hdl/fwdf_queue.sv */
// Two-entry queue between the converter front and the character back.
module fwdf_queue
   import fwdf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  digit_entry_type push_entry,
   input  logic            pop,
   output logic            q_valid,
   output logic            q_full,
   output digit_entry_type q_entry
);

   digit_entry_type    entries_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign q_valid = count_ff != '0;
   assign q_full  = count_ff == QCNT_W'(QDEPTH);
   assign q_entry = entries_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/fwdf_front.sv */
// Front: takes a value, splits sign and magnitude, converts to BCD.
module fwdf_front
   import fwdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      q_full,
   output logic                      push,
   output digit_entry_type           push_entry
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type     state_ff, state_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   bcd_type             bcd_ff, bcd_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SIG_W-1:0]    sig;

   // one double-dabble bit: add 3 to digits of 5 and up, then shift in
   function automatic bcd_type dabble_bit(bcd_type b, logic bit_in);
      bcd_type          t;
      logic [BCD_W-1:0] flat;
      t = b;
      for (int i = 0; i < DIGITS; i++) begin
         if (t[i] >= 4'd5) begin
            t[i] = t[i] + 4'd3;
         end
      end
      flat = t;
      flat = {flat[BCD_W-2:0], bit_in};
      return bcd_type'(flat);
   endfunction

   // count of significant digits, zero for a zero magnitude
   always_comb begin
      sig = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            sig = SIG_W'(i + 1);
         end
      end
   end

   assign req_stall = state_ff != F_IDLE;
   assign push      = (state_ff == F_PUSH) && !q_full;
   assign push_entry = '{neg: neg_ff, bcd: bcd_ff, sig: sig};

   always_comb begin
      bcd_type t;
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      t        = bcd_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               neg_in   = req_value[VALUE_W-1];
               mag_in   = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                               : VALUE_W'(req_value);
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            for (int k = 0; k < STEP_BITS; k++) begin
               t = dabble_bit(t, mag_ff[VALUE_W-1-k]);
            end
            bcd_in = t;
            mag_in = {mag_ff[VALUE_W-STEP_BITS-1:0], STEP_BITS'(0)};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
   end

endmodule

/* hdl/fwdf_back.sv */
// Back: walks the field left to right and emits one character per cycle while rsp_stall allows it.
module fwdf_back
   import fwdf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  fmt_cfg_type     cfg,
   input  logic            q_valid,
   input  digit_entry_type q_entry,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_character,
   output logic            rsp_last_char
);

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EMIT = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic              neg_ff, neg_in;
   bcd_type           bcd_ff, bcd_in;
   logic [SIG_W-1:0]  sig_ff, sig_in;
   logic [5:0]        minus_pos_ff, minus_pos_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;

   logic              frac_mode, after_point, digit_zone, out_ready;
   logic [5:0]        p6, f6, s6, q_s6;
   logic [DIG_IDX_W-1:0] dig_idx;
   logic [7:0]        ch, pad;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_last_char = last_ff;
   assign out_ready     = !rsp_valid_ff || !rsp_stall;
   assign pop           = (state_ff == B_IDLE) && q_valid;

   assign frac_mode   = cfg.frac != '0;
   assign p6          = 6'(pos_ff);
   assign f6          = 6'(cfg.frac);
   assign s6          = 6'(sig_ff);
   assign q_s6        = 6'(q_entry.sig);
   assign after_point = frac_mode && (p6 > f6);
   assign dig_idx     = after_point ? DIG_IDX_W'(pos_ff - 1'b1) : DIG_IDX_W'(pos_ff);
   assign pad         = (!frac_mode && cfg.zero_pad) ? CH_ZERO : CH_SPACE;

   // integer mode: rightmost plus significant digits; fixed point: all
   // positions through the first integer digit, then significant digits
   always_comb begin
      if (frac_mode) begin
         digit_zone = (p6 <= f6 + 6'd1) || (p6 <= s6);
      end else begin
         digit_zone = (pos_ff == '0) || (p6 < s6);
      end
   end

   always_comb begin
      if (frac_mode && p6 == f6) begin
         ch = CH_POINT;
      end else if (neg_ff && p6 == minus_pos_ff) begin
         ch = CH_MINUS;
      end else if (digit_zone) begin
         ch = CH_ZERO + 8'(bcd_ff[dig_idx]);
      end else begin
         ch = pad;
      end
   end

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      bcd_in       = bcd_ff;
      sig_in       = sig_ff;
      minus_pos_in = minus_pos_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               neg_in = q_entry.neg;
               bcd_in = q_entry.bcd;
               sig_in = q_entry.sig;
               pos_in = POS_W'(cfg.width - 1'b1);
               if (frac_mode) begin
                  minus_pos_in = (f6 + 6'd2 > q_s6 + 6'd1) ? f6 + 6'd2 : q_s6 + 6'd1;
               end else begin
                  minus_pos_in = q_s6;
               end
               state_in = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_ready) begin
               rsp_valid_in = 1'b1;
               char_in      = ch;
               last_in      = pos_ff == '0;
               pos_in       = pos_ff - 1'b1;
               if (pos_ff == '0) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff       <= neg_in;
      bcd_ff       <= bcd_in;
      sig_ff       <= sig_in;
      minus_pos_ff <= minus_pos_in;
      pos_ff       <= pos_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
   end

endmodule

/* hdl/fixed_width_decimal_formatter.sv */
// Top level of the fixed-width decimal formatter.
// Usage:
//   req_valid/req_stall/req_value: one signed 64-bit value per item, taken at
//     an edge with req_valid high and req_stall low.
//   rsp_valid/rsp_stall: one ASCII character per item, leftmost first;
//     rsp_last_char marks the rightmost character of the field.
//   csr_valid/csr_ready/csr_index/csr_wdata: register writes (0 field_width,
//     1 frac_digits, 2 zero_pad). csr_ready is always high; write only idle.
// Operation:
//   The front converts the magnitude to BCD four bits a cycle and keeps
//   req_stall high from acceptance until its result is pushed. The back emits
//   one character per cycle while rsp_stall allows it. A two-entry queue
//   decouples them, so the front can take a new value while the back still
//   emits the characters of the previous one.
// Reset: synchronous, clears both state machines, the queue and rsp_valid;
//   registers return to width 8, no fraction digits, space padding.
// Stall: a stalled response holds in the output register; the back waits,
//   the queue fills, and the front keeps req_stall high until it can push.
`include "fixed_width_decimal_formatter_macros.svh"
module fixed_width_decimal_formatter
   import fwdf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [VALUE_W-1:0]   req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last_char,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [FW_W-1:0]             csr_wdata
);

   // config registers
   logic [FW_W-1:0]   field_width_ff, field_width_in;
   logic [FW_W-1:0]   frac_digits_ff, frac_digits_in;
   logic              zero_pad_ff, zero_pad_in;
   fmt_cfg_type       cfg;

   // front to queue to back
   logic              push, q_full, q_valid, q_pop;
   digit_entry_type   push_entry, q_entry;

   // output character is a decimal digit
   logic              rsp_is_digit;

   assign csr_ready = 1'b1;

   always_comb begin
      field_width_in = field_width_ff;
      frac_digits_in = frac_digits_ff;
      zero_pad_in    = zero_pad_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIELD_WIDTH: field_width_in = csr_wdata;
            CSR_FRAC_DIGITS: frac_digits_in = csr_wdata;
            CSR_ZERO_PAD:    zero_pad_in    = csr_wdata[0];
            default: ;  // unknown index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_width_ff <= FW_W'(8);
         frac_digits_ff <= '0;
         zero_pad_ff    <= 1'b0;
      end else begin
         field_width_ff <= field_width_in;
         frac_digits_ff <= frac_digits_in;
         zero_pad_ff    <= zero_pad_in;
      end
   end

   // width 0 acts as 1, anything above the maximum is clamped
   always_comb begin
      if (field_width_ff == '0) begin
         cfg.width = FW_W'(1);
      end else if (field_width_ff > FW_W'(MAX_WIDTH)) begin
         cfg.width = FW_W'(MAX_WIDTH);
      end else begin
         cfg.width = field_width_ff;
      end
      cfg.frac     = frac_digits_ff;
      cfg.zero_pad = zero_pad_ff;
   end

   fwdf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   fwdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_entry    (q_entry)
   );

   fwdf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   assign rsp_is_digit = (rsp_character >= CH_ZERO) && (rsp_character <= CH_NINE);

   // back only pops a filled queue, front only pushes into a free slot
   `FWDF_ASSERT_HOLDS(a_pop_nonempty, clock, reset, q_pop, q_valid)
   `FWDF_ASSERT_HOLDS(a_push_has_room, clock, reset, push, !q_full)
   `FWDF_ASSERT_NEVER(a_queue_count, clock, reset, q_full && !q_valid)
   // rightmost character of every field is a digit
   `FWDF_ASSERT_HOLDS(a_last_is_digit, clock, reset, rsp_valid && rsp_last_char, rsp_is_digit)

endmodule
